[rtl/variable_length_message_ring_defines.svh]
`ifndef VARIABLE_LENGTH_MESSAGE_RING_DEFINES_SVH
`define VARIABLE_LENGTH_MESSAGE_RING_DEFINES_SVH

// Assertion helpers for the message ring. Each use names its label, clock,
// active-low reset, the two sides of the implication and the report text.

// Same-cycle implication.
`define VLMR_ASSERT_IMPLIES(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VLMR_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vlmr_pkg.sv]
`default_nettype none

package vlmr_pkg;

	// Ring geometry; the ring depth must be a power of two.
	localparam int unsigned RING_WORDS = 1024;
	localparam int unsigned ADDR_W     = $clog2(RING_WORDS);
	localparam int unsigned PTR_W      = ADDR_W + 1;

	// Field widths.
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BYTES_W  = 16;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned MAX_W    = 12;
	localparam int unsigned STATUS_W = 3;

	// Word count of a byte length, and the width used for space checks.
	localparam int unsigned WORDS_W = BYTES_W - 1;
	localparam int unsigned SPACE_W = ((WORDS_W > PTR_W) ? WORDS_W : PTR_W) + 1;

	localparam logic [MAX_W-1:0] MAX_BYTES_RESET = MAX_W'(4092);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_BEGIN  = OP_W'(0);
	localparam logic [OP_W-1:0] OP_APPEND = OP_W'(1);
	localparam logic [OP_W-1:0] OP_READ   = OP_W'(2);

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK     = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STAT_FULL   = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] STAT_BADLEN = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] STAT_SEQ    = STATUS_W'(4);

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_DATA
	} vlmr_state_t;

	// One result as it sits in the output register.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   word;
		logic [BYTES_W-1:0]  length;
		logic                last;
		logic                committed;
	} vlmr_result_t;

	// Number of data words for a byte length, rounded up.
	function automatic logic [WORDS_W-1:0] words_of(input logic [BYTES_W-1:0] bytes);
		logic [BYTES_W:0] sum;
		sum = {1'b0, bytes} + (BYTES_W + 1)'(3);
		return sum[BYTES_W:2];
	endfunction

endpackage

`default_nettype wire

[rtl/variable_length_message_ring.sv]
`default_nettype none

`include "variable_length_message_ring_defines.svh"

// Ring buffer of variable-length messages held in one single-port-write,
// registered-read RAM of RING_WORDS 32-bit words. Each message is a header
// word with its byte length followed by its data words. A begin request
// checks sequence, a nonzero length within the configured maximum, then
// space, and writes the header; append requests fill the data words, and
// the last one raises committed and makes the message readable. Items are
// handled one at a time. A begin or an append has its result registered at
// the edge that accepts it. A read while a message is already being read
// fetches the next data word; the first read of a message fetches the
// header and then the data word, each through the RAM's registered read
// port. A read with nothing committed answers empty at the accepting edge.
// The RAM needs no clearing after reset: only committed words are read.
module variable_length_message_ring (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [vlmr_pkg::MAX_W-1:0]    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [vlmr_pkg::OP_W-1:0]     opcode,
	input  wire logic [vlmr_pkg::BYTES_W-1:0]  message_bytes,
	input  wire logic [vlmr_pkg::WORD_W-1:0]   data_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [vlmr_pkg::STATUS_W-1:0] status,
	output logic      [vlmr_pkg::WORD_W-1:0]   read_word,
	output logic      [vlmr_pkg::BYTES_W-1:0]  read_length,
	output logic                               last_word,
	output logic                               committed
);

	import vlmr_pkg::*;

	// Control and pointer state.
	vlmr_state_t        state_q, state_d;
	logic [PTR_W-1:0]   reserve_q, reserve_d;
	logic [PTR_W-1:0]   commit_q, commit_d;
	logic [PTR_W-1:0]   rdptr_q, rdptr_d;
	logic [PTR_W-1:0]   wr_left_q, wr_left_d;
	logic               wr_open_q, wr_open_d;
	logic [PTR_W-1:0]   rd_left_q, rd_left_d;
	logic [BYTES_W-1:0] rd_len_q, rd_len_d;
	logic [MAX_W-1:0]   max_bytes_q;

	// Output register.
	logic               out_valid_q, out_valid_d;
	vlmr_result_t       res_q, res_d, res_new;
	logic               res_load;

	// RAM port signals.
	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;

	// Datapath helpers.
	logic               in_accept;
	logic [WORDS_W-1:0] beg_words;
	logic [PTR_W-1:0]   used;
	logic [SPACE_W-1:0] used_ext, need, ring_ext;
	logic [PTR_W-1:0]   app_ptr;
	logic [PTR_W-1:0]   rdptr_inc;
	logic [BYTES_W-1:0] hdr_len;
	logic [PTR_W-1:0]   hdr_words;

	vlmr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (RING_WORDS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A new request is taken only when idle and the output slot frees up.
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	// Space and address arithmetic.
	assign beg_words = words_of(message_bytes);
	assign used      = reserve_q - rdptr_q;
	assign used_ext  = SPACE_W'(used);
	assign need      = SPACE_W'(beg_words) + SPACE_W'(1);
	assign ring_ext  = SPACE_W'(RING_WORDS);
	assign app_ptr   = reserve_q - wr_left_q;
	assign rdptr_inc = rdptr_q + PTR_W'(1);
	assign hdr_len   = ram_rdata[BYTES_W-1:0];
	assign hdr_words = PTR_W'(words_of(hdr_len));

	// Next state, pointer updates, RAM accesses and the result.
	always_comb begin
		state_d   = state_q;
		reserve_d = reserve_q;
		commit_d  = commit_q;
		rdptr_d   = rdptr_q;
		wr_left_d = wr_left_q;
		wr_open_d = wr_open_q;
		rd_left_d = rd_left_q;
		rd_len_d  = rd_len_q;
		ram_we    = 1'b0;
		ram_waddr = reserve_q[ADDR_W-1:0];
		ram_wdata = WORD_W'(message_bytes);
		ram_re    = 1'b0;
		ram_raddr = rdptr_q[ADDR_W-1:0];
		res_load  = 1'b0;
		res_new   = '0;
		res_new.status = STAT_OK;

		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (opcode)
						OP_BEGIN: begin
							res_load = 1'b1;
							if (wr_open_q) begin
								res_new.status = STAT_SEQ;
							end else if (message_bytes == '0 ||
									message_bytes > BYTES_W'(max_bytes_q)) begin
								res_new.status = STAT_BADLEN;
							end else if (used_ext > ring_ext || need > ring_ext - used_ext) begin
								res_new.status = STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								reserve_d = reserve_q + PTR_W'(need);
								wr_left_d = PTR_W'(beg_words);
								wr_open_d = 1'b1;
							end
						end
						OP_APPEND: begin
							res_load = 1'b1;
							if (!wr_open_q || wr_left_q == '0) begin
								res_new.status = STAT_SEQ;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = app_ptr[ADDR_W-1:0];
								ram_wdata = data_word;
								wr_left_d = wr_left_q - PTR_W'(1);
								if (wr_left_q == PTR_W'(1)) begin
									wr_open_d         = 1'b0;
									commit_d          = reserve_q;
									res_new.committed = 1'b1;
								end
							end
						end
						OP_READ: begin
							if (rd_left_q == '0) begin
								if (rdptr_q == commit_q) begin
									res_load       = 1'b1;
									res_new.status = STAT_EMPTY;
								end else begin
									ram_re  = 1'b1;
									state_d = ST_HDR;
								end
							end else begin
								ram_re  = 1'b1;
								state_d = ST_DATA;
							end
						end
						default: begin
							res_load       = 1'b1;
							res_new.status = STAT_SEQ;
						end
					endcase
				end
			end
			ST_HDR: begin
				// Header word is back; fetch the first data word behind it, or answer empty for a message with no data words.
				rdptr_d   = rdptr_inc;
				rd_len_d  = hdr_len;
				rd_left_d = hdr_words;
				if (hdr_words == '0) begin
					res_load       = 1'b1;
					res_new.status = STAT_EMPTY;
					state_d        = ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = rdptr_inc[ADDR_W-1:0];
					state_d   = ST_DATA;
				end
			end
			ST_DATA: begin
				rdptr_d        = rdptr_inc;
				rd_left_d      = rd_left_q - PTR_W'(1);
				res_load       = 1'b1;
				res_new.word   = ram_rdata;
				res_new.length = rd_len_q;
				res_new.last   = (rd_left_q == PTR_W'(1));
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output slot: load a new result, or drop the one just taken.
	always_comb begin
		out_valid_d = out_valid_q;
		res_d       = res_q;
		if (res_load) begin
			out_valid_d = 1'b1;
			res_d       = res_new;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pointers, counters, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_q   <= '0;
			commit_q    <= '0;
			rdptr_q     <= '0;
			wr_left_q   <= '0;
			wr_open_q   <= 1'b0;
			rd_left_q   <= '0;
			rd_len_q    <= '0;
			max_bytes_q <= MAX_BYTES_RESET;
			out_valid_q <= 1'b0;
		end else begin
			reserve_q   <= reserve_d;
			commit_q    <= commit_d;
			rdptr_q     <= rdptr_d;
			wr_left_q   <= wr_left_d;
			wr_open_q   <= wr_open_d;
			rd_left_q   <= rd_left_d;
			rd_len_q    <= rd_len_d;
			out_valid_q <= out_valid_d;
			if (cfg_wen) begin
				max_bytes_q <= cfg_wdata;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign read_word   = res_q.word;
	assign read_length = res_q.length;
	assign last_word   = res_q.last;
	assign committed   = res_q.committed;

	// The reserved region never grows past the ring.
	`VLMR_ASSERT_IMPLIES(a_used_bound, clk, arst_n, 1'b1, used_ext <= ring_ext,
		"reserved words exceed the ring")

	// A closed writer has no words outstanding.
	`VLMR_ASSERT_IMPLIES(a_closed_no_left, clk, arst_n, !wr_open_q, wr_left_q == '0,
		"write counter nonzero with no open message")

	// While a read is in flight the output slot is empty.
	`VLMR_ASSERT_IMPLIES(a_busy_slot_free, clk, arst_n, state_q != ST_IDLE, !out_valid_q,
		"read in flight while a result is still pending")

	// A header fetch is always followed by a data fetch or an empty result.
	`VLMR_ASSERT_NEXT(a_hdr_next, clk, arst_n, state_q == ST_HDR,
		state_q == ST_DATA || (out_valid_q && res_q.status == STAT_EMPTY),
		"header fetch not followed by data fetch")

endmodule

`default_nettype wire

[rtl/vlmr_ram.sv]
`default_nettype none

module vlmr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
